// File: design/rld_pkg.sv
// shared types and constants of the run list decoder
package rld_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned CB_W   = 22;
  localparam logic [CB_W-1:0] CB_RESET = 22'd4096;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET,
    PH_ERROR
  } phase_e;

  typedef struct packed {
    logic run;
    logic sparse;
    logic list_end;
    logic fmt_err;
    logic clr;
  } rld_flags_t;

  typedef struct packed {
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] delta;
    rld_flags_t        flags;
  } rld_run_t;

  typedef struct packed {
    logic [WORD_W-1:0] len_bytes;
    logic [WORD_W-1:0] delta_bytes;
    rld_flags_t        flags;
  } rld_scaled_t;

endpackage

// File: design/rld_decoder.sv
// byte register, header and field decoding, run result register
module rld_decoder import rld_pkg::*; #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       list_start_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output rld_run_t   res_o
);

  localparam int unsigned LenW = 8 * MAX_FIELD_BYTES;
  localparam int unsigned PosW = (MAX_FIELD_BYTES > 1) ? $clog2(MAX_FIELD_BYTES) : 1;
  localparam logic [3:0] MaxNib = 4'(MAX_FIELD_BYTES);

  logic            v0_q;
  logic [7:0]      byte0_q;
  logic            ls0_q;
  phase_e          phase_q, phase_d, phase_eff;
  logic [3:0]      bl_q, bl_d;
  logic [3:0]      osize_q, osize_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [LenW-1:0] len_q, len_d;
  logic [WORD_W-1:0] delta_q, delta_d;
  logic            pend_q, pend_d;
  logic            v1_q;
  rld_run_t        res_q, rd;
  logic            rv;

  logic            s1_free, consume;
  logic [3:0]      lnib, onib;
  logic            bad, last;
  logic [LenW-1:0] len_shift;
  logic [WORD_W-1:0] byte_ext, delta_shift;

  assign s1_free    = !v1_q || res_ready_i;
  assign consume    = v0_q && s1_free;
  assign in_ready_o = !v0_q || consume;

  assign lnib      = byte0_q[3:0];
  assign onib      = byte0_q[7:4];
  assign bad       = (lnib > MaxNib) || (onib > MaxNib);
  assign last      = (bl_q == 4'd1);
  assign phase_eff = ls0_q ? PH_HEADER : phase_q;

  assign len_shift   = LenW'(byte0_q) << {pos_q, 3'b000};
  assign byte_ext    = last ? {{(WORD_W-8){byte0_q[7]}}, byte0_q}
                            : {{(WORD_W-8){1'b0}}, byte0_q};
  assign delta_shift = byte_ext << {pos_q, 3'b000};

  always_comb begin
    phase_d = phase_q;
    if (consume) begin
      case (phase_eff)
        PH_HEADER: begin
          if (byte0_q == 8'd0) begin
            phase_d = PH_HEADER;
          end else if (bad) begin
            phase_d = PH_ERROR;
          end else if (lnib != 4'd0) begin
            phase_d = PH_LENGTH;
          end else if (onib != 4'd0) begin
            phase_d = PH_OFFSET;
          end else begin
            phase_d = PH_HEADER;
          end
        end
        PH_LENGTH: begin
          if (last) begin
            phase_d = (osize_q == 4'd0) ? PH_HEADER : PH_OFFSET;
          end
        end
        PH_OFFSET: begin
          if (last) begin
            phase_d = PH_HEADER;
          end
        end
        PH_ERROR: phase_d = PH_ERROR;
        default:  phase_d = PH_HEADER;
      endcase
    end
  end

  always_comb begin
    bl_d    = bl_q;
    osize_d = osize_q;
    pos_d   = pos_q;
    len_d   = len_q;
    delta_d = delta_q;
    pend_d  = pend_q;
    rv      = 1'b0;
    rd      = '0;
    rd.flags.clr = pend_q || ls0_q;
    if (consume) begin
      case (phase_eff)
        PH_HEADER: begin
          if (byte0_q == 8'd0) begin
            rv = 1'b1;
            rd.flags.list_end = 1'b1;
          end else if (bad) begin
            rv = 1'b1;
            rd.flags.fmt_err = 1'b1;
          end else begin
            len_d   = '0;
            delta_d = '0;
            pos_d   = '0;
            osize_d = onib;
            if (lnib != 4'd0) begin
              bl_d = lnib;
            end else if (onib == 4'd0) begin
              rv = 1'b1;
              rd.flags.sparse = 1'b1;
            end else begin
              bl_d = onib;
            end
          end
        end
        PH_LENGTH: begin
          len_d = len_q | len_shift;
          pos_d = pos_q + 1'b1;
          bl_d  = bl_q - 4'd1;
          if (last) begin
            if (osize_q == 4'd0) begin
              rv = 1'b1;
              rd.flags.sparse = 1'b1;
              rd.len = WORD_W'(len_d);
            end else begin
              bl_d  = osize_q;
              pos_d = '0;
            end
          end
        end
        PH_OFFSET: begin
          delta_d = delta_q | delta_shift;
          pos_d   = pos_q + 1'b1;
          bl_d    = bl_q - 4'd1;
          if (last) begin
            rv = 1'b1;
            rd.flags.run = 1'b1;
            rd.len   = WORD_W'(len_q);
            rd.delta = delta_d;
          end
        end
        PH_ERROR: begin
          rv = 1'b0;
        end
        default: begin
          rv = 1'b0;
        end
      endcase
      pend_d = (pend_q || ls0_q) && !rv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      phase_q <= PH_HEADER;
      bl_q    <= '0;
      osize_q <= '0;
      pos_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v0_q <= in_valid_i;
      end
      if (s1_free) begin
        v1_q <= rv;
      end
      phase_q <= phase_d;
      bl_q    <= bl_d;
      osize_q <= osize_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte0_q <= data_byte_i;
      ls0_q   <= list_start_i;
    end
    len_q   <= len_d;
    delta_q <= delta_d;
    if (rv) begin
      res_q <= rd;
    end
  end

  assign res_valid_o = v1_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  property p_one_kind;
    @(posedge clk_i) disable iff (!rst_ni)
      v1_q |-> $onehot({res_q.flags.run, res_q.flags.sparse,
                        res_q.flags.list_end, res_q.flags.fmt_err});
  endproperty
  a_one_kind: assert property (p_one_kind) else $error("result kind not one-hot");

  property p_field_count;
    @(posedge clk_i) disable iff (!rst_ni)
      (phase_q == PH_LENGTH || phase_q == PH_OFFSET) |->
        (bl_q != 4'd0 && bl_q <= MaxNib);
  endproperty
  a_field_count: assert property (p_field_count) else $error("byte count out of range");

  property p_error_silent;
    @(posedge clk_i) disable iff (!rst_ni)
      (consume && phase_q == PH_ERROR && !ls0_q) |=> (phase_q == PH_ERROR);
  endproperty
  a_error_silent: assert property (p_error_silent) else $error("left error without list start");

  property p_clear_kept;
    @(posedge clk_i) disable iff (!rst_ni)
      (consume && ls0_q && !rv) |=> pend_q;
  endproperty
  a_clear_kept: assert property (p_clear_kept) else $error("list start clear lost");
`endif

endmodule

// File: design/rld_scaler.sv
// two-stage multiply of cluster counts by the cluster size
module rld_scaler import rld_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rld_run_t        in_i,
  input  logic [CB_W-1:0] cb_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rld_scaled_t     out_o
);

  localparam int unsigned LoW = 32 + CB_W;

  logic           v2_q, v3_q;
  logic           s2_free, s3_free;
  logic [LoW-1:0] lp_lo_q, dp_lo_q, lp_lo_d, dp_lo_d;
  logic [31:0]    lp_hi_q, dp_hi_q, lp_hi_d, dp_hi_d;
  rld_flags_t     f2_q;
  rld_scaled_t    out_q, out_d;

  assign s3_free    = !v3_q || out_ready_i;
  assign s2_free    = !v2_q || s3_free;
  assign in_ready_o = s2_free;

  assign lp_lo_d = LoW'(in_i.len[31:0]) * LoW'(cb_i);
  assign dp_lo_d = LoW'(in_i.delta[31:0]) * LoW'(cb_i);
  assign lp_hi_d = in_i.len[63:32] * 32'(cb_i);
  assign dp_hi_d = in_i.delta[63:32] * 32'(cb_i);

  always_comb begin
    out_d.len_bytes   = WORD_W'(lp_lo_q) + {lp_hi_q, 32'd0};
    out_d.delta_bytes = WORD_W'(dp_lo_q) + {dp_hi_q, 32'd0};
    out_d.flags       = f2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (s2_free) begin
        v2_q <= in_valid_i;
      end
      if (s3_free) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s2_free) begin
      lp_lo_q <= lp_lo_d;
      lp_hi_q <= lp_hi_d;
      dp_lo_q <= dp_lo_d;
      dp_hi_q <= dp_hi_d;
      f2_q    <= in_i.flags;
    end
    if (v2_q && s3_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_o       = out_q;

endmodule

// File: design/rld_accum.sv
// running offset accumulation and output register
module rld_accum import rld_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rld_scaled_t       in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] run_length_bytes_o,
  output logic [WORD_W-1:0] run_start_bytes_o,
  output logic              run_sparse_o,
  output logic              list_end_o,
  output logic              format_error_o
);

  logic              vo_q;
  logic [WORD_W-1:0] ro_q;
  logic [WORD_W-1:0] base, sum;
  logic              load;
  logic [WORD_W-1:0] len_q, start_q;
  logic              sparse_q, end_q, err_q;

  assign in_ready_o = !vo_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign base       = in_i.flags.clr ? '0 : ro_q;
  assign sum        = base + in_i.delta_bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
      ro_q <= '0;
    end else begin
      if (in_ready_o) begin
        vo_q <= in_valid_i;
      end
      if (load) begin
        ro_q <= sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      len_q    <= in_i.len_bytes;
      start_q  <= in_i.flags.run ? sum : '0;
      sparse_q <= in_i.flags.sparse;
      end_q    <= in_i.flags.list_end;
      err_q    <= in_i.flags.fmt_err;
    end
  end

  assign out_valid_o        = vo_q;
  assign run_length_bytes_o = len_q;
  assign run_start_bytes_o  = start_q;
  assign run_sparse_o       = sparse_q;
  assign list_end_o         = end_q;
  assign format_error_o     = err_q;

endmodule

// File: design/ntfs_run_list_decoder_unit.sv
// top level of the run list decoder: config register and pipeline
// takes one byte per cycle back to back unless the output stalls, no gaps between runs
// stages: byte register, decode register, two multiply stages, output register
// the cluster-size multiply is split into 32-bit halves over two stages
// reset clears the running offset, puts the decoder in header phase, cluster size 4096
module ntfs_run_list_decoder_unit import rld_pkg::*; #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CB_W-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              list_start_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] run_length_bytes_o,
  output logic [WORD_W-1:0] run_start_bytes_o,
  output logic              run_sparse_o,
  output logic              list_end_o,
  output logic              format_error_o
);

  logic [CB_W-1:0] cb_q;
  logic            dec_valid, dec_ready;
  rld_run_t        dec_res;
  logic            scl_valid, scl_ready;
  rld_scaled_t     scl_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_q <= CB_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cb_q <= cfg_data_i;
    end
  end

  rld_decoder #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .list_start_i(list_start_i),
    .res_valid_o (dec_valid),
    .res_ready_i (dec_ready),
    .res_o       (dec_res)
  );

  rld_scaler u_scaler (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (dec_valid),
    .in_ready_o (dec_ready),
    .in_i       (dec_res),
    .cb_i       (cb_q),
    .out_valid_o(scl_valid),
    .out_ready_i(scl_ready),
    .out_o      (scl_res)
  );

  rld_accum u_accum (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (scl_valid),
    .in_ready_o        (scl_ready),
    .in_i              (scl_res),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .run_length_bytes_o(run_length_bytes_o),
    .run_start_bytes_o (run_start_bytes_o),
    .run_sparse_o      (run_sparse_o),
    .list_end_o        (list_end_o),
    .format_error_o    (format_error_o)
  );

endmodule

// File: test/tb_top.sv
// testbench for the ntfs run list decoder: directed and random byte streams checked per result
`timescale 1ns / 1ps

module tb_top import rld_pkg::*; ();

  localparam int MAX_FIELD = 8;
  localparam int WATCHDOG  = 4000;
  localparam int DRAIN     = 20;

  typedef struct packed {
    logic [WORD_W-1:0] len_bytes;
    logic [WORD_W-1:0] start_bytes;
    logic              sparse;
    logic              list_end;
    logic              fmt_err;
  } run_result_t;

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CB_W-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [7:0]        data_byte_i = '0;
  logic              list_start_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [WORD_W-1:0] run_length_bytes_o;
  logic [WORD_W-1:0] run_start_bytes_o;
  logic              run_sparse_o;
  logic              list_end_o;
  logic              format_error_o;

  run_result_t runs_due[$];
  run_result_t got_run;
  run_result_t want_run;
  int          mismatch_cnt = 0;
  int          items_sent = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  bit          want_start = 1'b1;

  // decoder state mirror
  phase_e            ph = PH_HEADER;
  logic [3:0]        left_cnt = '0;
  logic [3:0]        off_size = '0;
  logic [2:0]        pos = '0;
  logic [WORD_W-1:0] len_acc = '0;
  logic [WORD_W-1:0] delta_acc = '0;
  logic [WORD_W-1:0] run_offset = '0;
  logic [CB_W-1:0]   clus_bytes = CB_RESET;

  ntfs_run_list_decoder_unit #(
    .MAX_FIELD_BYTES(MAX_FIELD)
  ) DUT (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .list_start_i      (list_start_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .run_length_bytes_o(run_length_bytes_o),
    .run_start_bytes_o (run_start_bytes_o),
    .run_sparse_o      (run_sparse_o),
    .list_end_o        (list_end_o),
    .format_error_o    (format_error_o)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // works out the result, if any, of one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic s);
    logic [3:0]        ls;
    logic [3:0]        os;
    logic [WORD_W-1:0] d;
    run_result_t       r;
    r = '0;
    if (s) begin
      run_offset = '0;
      ph = PH_HEADER;
    end
    case (ph)
      PH_HEADER: begin
        ls = b[3:0];
        os = b[7:4];
        if (b == 8'h00) begin
          r.list_end = 1'b1;
          runs_due = {runs_due, r};
        end else if (ls > MAX_FIELD || os > MAX_FIELD) begin
          ph = PH_ERROR;
          r.fmt_err = 1'b1;
          runs_due = {runs_due, r};
        end else begin
          len_acc = '0;
          delta_acc = '0;
          pos = '0;
          off_size = os;
          if (ls != 0) begin
            left_cnt = ls;
            ph = PH_LENGTH;
          end else begin
            left_cnt = os;
            ph = PH_OFFSET;
          end
        end
      end
      PH_LENGTH: begin
        len_acc = len_acc | (WORD_W'(b) << (8 * pos));
        pos = pos + 3'd1;
        left_cnt = left_cnt - 4'd1;
        if (left_cnt == 0) begin
          if (off_size == 0) begin
            r.len_bytes = len_acc * WORD_W'(clus_bytes);
            r.sparse = 1'b1;
            runs_due = {runs_due, r};
            ph = PH_HEADER;
          end else begin
            left_cnt = off_size;
            pos = '0;
            ph = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        delta_acc = delta_acc | (WORD_W'(b) << (8 * pos));
        pos = pos + 3'd1;
        left_cnt = left_cnt - 4'd1;
        if (left_cnt == 0) begin
          d = delta_acc;
          if (off_size < 8 && d[8 * off_size - 1])
            d = d | (~64'd0 << (8 * off_size));
          run_offset = run_offset + d * WORD_W'(clus_bytes);
          r.len_bytes = len_acc * WORD_W'(clus_bytes);
          r.start_bytes = run_offset;
          runs_due = {runs_due, r};
          ph = PH_HEADER;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [7:0] b, input logic s);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    list_start_i <= s;
    do @(posedge clk); while (!in_ready_o);
    decode_byte(b, s);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (runs_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_cluster(input logic [CB_W-1:0] v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk); while (!cfg_ready_o);
    clus_bytes = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // header plus fields, cut short after cut field bytes
  task automatic send_run(input int ls, input int os, input logic s, input int cut);
    int n;
    n = (cut < ls + os) ? cut : ls + os;
    send_item({4'(os), 4'(ls)}, s);
    for (int i = 0; i < n; i++) send_item(rand_byte(), 1'b0);
  endtask

  task automatic send_mixed(input int n);
    int   stop_at;
    int   r;
    int   ls;
    logic s;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      s = want_start || ($urandom_range(15) == 0);
      want_start = 1'b0;
      if (r < 70) begin
        send_run($urandom_range(MAX_FIELD), $urandom_range(MAX_FIELD), s, 99);
      end else if (r < 80) begin
        send_item(8'h00, s);
      end else if (r < 87) begin
        if ($urandom_range(1))
          send_item({4'($urandom_range(15)), 4'($urandom_range(15, 9))}, s);
        else
          send_item({4'($urandom_range(15, 9)), 4'($urandom_range(15))}, s);
        repeat ($urandom_range(3)) send_item(rand_byte(), 1'b0);
        want_start = ($urandom_range(4) != 0);
      end else if (r < 94) begin
        ls = $urandom_range(MAX_FIELD, 1);
        r = $urandom_range(MAX_FIELD);
        send_run(ls, r, s, $urandom_range(ls + r - 1));
        want_start = 1'b1;
      end else begin
        send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_directed();
    send_item(8'h11, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b0);
    // sparse run, then a run with no length field
    send_item(8'h01, 1'b0);
    send_item(8'h05, 1'b0);
    send_item(8'h10, 1'b0);
    send_item(8'h7F, 1'b0);
    // widest fields, most negative delta
    send_item(8'h88, 1'b0);
    repeat (8) send_item(8'hFF, 1'b0);
    repeat (7) send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0);
    // bad nibbles, ignored byte, then a new list whose header is also bad
    send_item(8'h09, 1'b0);
    send_item(8'h11, 1'b0);
    send_item(8'h90, 1'b1);
    want_start = 1'b1;
    wait_idle();
  endtask

  task automatic test_cluster_extremes();
    logic [CB_W-1:0] sizes[5];
    sizes = '{22'd0, 22'd1, {CB_W{1'b1}}, 22'd512, 22'd2097152};
    foreach (sizes[i]) begin
      set_cluster(sizes[i]);
      want_start = 1'b1;
      send_mixed(25);
    end
  endtask

  task automatic test_idle_phases();
    int idles[4];
    int stalls[4];
    idles  = '{0, 49, 0, 9};
    stalls = '{0, 0, 49, 9};
    for (int p = 0; p < 4; p++) begin
      set_cluster(CB_W'($urandom_range(2097152, 512)));
      idle_pct  = idles[p];
      stall_pct = stalls[p];
      send_mixed(200);
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 300;
    send_mixed(80);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_run = '{run_length_bytes_o, run_start_bytes_o, run_sparse_o, list_end_o,
                  format_error_o};
      if (runs_due.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected result: len %h start %h sparse %b end %b err %b",
                   got_run.len_bytes, got_run.start_bytes, got_run.sparse,
                   got_run.list_end, got_run.fmt_err);
        mismatch_cnt++;
      end else begin
        want_run = runs_due.pop_front();
        if (got_run.len_bytes !== want_run.len_bytes ||
            got_run.start_bytes !== want_run.start_bytes ||
            got_run.sparse !== want_run.sparse ||
            got_run.list_end !== want_run.list_end ||
            got_run.fmt_err !== want_run.fmt_err) begin
          if (mismatch_cnt < 10) begin
            $display("mismatch exp: len %h start %h sparse %b end %b err %b",
                     want_run.len_bytes, want_run.start_bytes, want_run.sparse,
                     want_run.list_end, want_run.fmt_err);
            $display("         got: len %h start %h sparse %b end %b err %b",
                     got_run.len_bytes, got_run.start_bytes, got_run.sparse,
                     got_run.list_end, got_run.fmt_err);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_directed();
    test_cluster_extremes();
    test_idle_phases();
    test_backpressure();
    wait_idle();
    if (mismatch_cnt == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
